// File: src/ipc_pkg.sv
`default_nettype none

package ipc_pkg;

    localparam int MAX_LEN = 64;
    localparam int VAL_W   = 32;
    localparam int TOT_W   = 11;
    localparam int CNT_W   = $clog2(MAX_LEN);
    localparam int SUM_W   = ((CNT_W > TOT_W) ? CNT_W : TOT_W) + 1;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_in;

    typedef struct packed {
        logic [TOT_W-1:0] inversion_total;
        logic             overflow;
    } t_out;

    // element travelling down the cell chain
    typedef struct packed {
        logic                    vld;
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic                    placed;
        logic [CNT_W-1:0]        cnt;
    } t_token;

endpackage

`default_nettype wire

// File: src/ipc_cell.sv
`default_nettype none

module ipc_cell
    import ipc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_adv,
    input  wire t_token i_tok,
    output t_token      o_tok
);

    logic                    r_full;
    logic signed [VAL_W-1:0] r_val;
    t_token                  r_tok;
    t_token                  n_tok;
    logic                    w_gt;
    logic                    w_store;

    always_comb begin
        w_gt    = r_full && (r_val > i_tok.value);
        w_store = i_tok.vld && !i_tok.placed && !r_full;
        n_tok   = i_tok;
        if (i_tok.vld && !i_tok.placed && w_gt) begin
            n_tok.cnt = i_tok.cnt + CNT_W'(1);
        end
        if (w_store) begin
            n_tok.placed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_tok  <= '0;
        end else if (i_adv) begin
            r_tok <= n_tok;
            // end of sequence empties the cell behind the last element
            if (i_tok.vld && i_tok.last) begin
                r_full <= 1'b0;
            end else if (w_store) begin
                r_full <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && w_store) begin
            r_val <= i_tok.value;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// File: src/ipc_tail.sv
`default_nettype none

module ipc_tail
    import ipc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_adv,
    input  wire t_token i_tok,
    input  wire logic   i_out_ready,
    output logic        o_out_valid,
    output t_out        o_out_data
);

    localparam logic [SUM_W-1:0] TOT_MAX = SUM_W'((2 ** TOT_W) - 1);

    logic [TOT_W-1:0] r_total;
    logic             r_ovf;
    logic             r_out_valid;
    t_out             r_out;
    logic [SUM_W-1:0] w_sum;
    logic [TOT_W-1:0] n_total;
    logic             n_ovf;

    always_comb begin
        w_sum = SUM_W'(r_total) + (i_tok.placed ? SUM_W'(i_tok.cnt) : SUM_W'(0));
        n_total = (w_sum > TOT_MAX) ? TOT_W'(TOT_MAX) : w_sum[TOT_W-1:0];
        n_ovf   = r_ovf || !i_tok.placed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_adv && i_tok.vld) begin
                if (i_tok.last) begin
                    r_total <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_total <= n_total;
                    r_ovf   <= n_ovf;
                end
            end
            if (i_adv) begin
                r_out_valid <= i_tok.vld && i_tok.last;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_tok.vld && i_tok.last) begin
            r_out.inversion_total <= n_total;
            r_out.overflow        <= n_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: src/inversion_pair_counter.sv
// A result is registered in the tail once the transaction carrying last has passed through every cell of the chain.
// Throughput: one input transaction per cycle; each element steps one cell of the chain per cycle.
// The whole chain stalls only while a finished result waits for o_out_ready.
// Reset (i_rst_n low, synchronous): all cells empty, running total and overflow cleared,
// no result pending. Stored values themselves are not reset.
`default_nettype none

module inversion_pair_counter
    import ipc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    // Chain of MAX_LEN cells. Cells fill front to back, one stored element each.
    // An element walks the chain, counting the greater stored values it passes,
    // and settles into the first empty cell (it keeps walking as a token so the
    // tail can add its count). An element that finds no empty cell is overflow:
    // its count is dropped at the tail. A last element clears every cell it
    // passes, so the next sequence follows directly behind it.

    t_token w_tok [MAX_LEN+1];
    t_token w_head;
    logic   w_adv;

    // advance everything unless the result register is held
    assign w_adv      = !(o_out_valid && !i_out_ready);
    assign o_in_ready = w_adv;

    always_comb begin
        w_head.vld    = i_in_valid;
        w_head.value  = i_in_data.value;
        w_head.last   = i_in_data.last;
        w_head.placed = 1'b0;
        w_head.cnt    = '0;
    end

    assign w_tok[0] = w_head;

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        ipc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // per-sequence accumulation and result register
    ipc_tail u_tail (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_tok       (w_tok[MAX_LEN]),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
